// ----- rtl/mdvo_pkg.sv -----
// Package for the minimum-degree vertex ordering block.
// Holds payload structs, the sequencer state type and size constants.
// No dependencies.
package mdvo_pkg;

  localparam int MaxVertices = 64;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last_row;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] position;
    logic [5:0] vertex;
    logic       last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DEGREE,
    ST_SEARCH,
    ST_UPDATE,
    ST_FLUSH,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/mdvo_lane.sv -----
// One lane: holds the degree and selected flag of one vertex.
// Depends on nothing outside this file; pure datapath.
module mdvo_lane (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [6:0] init_degree,
  input  logic       select,
  input  logic       dec,
  output logic [6:0] degree,
  output logic       selected
);

  always_ff @(posedge clk) begin
    if (rst) begin
      degree   <= '0;
      selected <= 1'b0;
    end else if (load) begin
      degree   <= init_degree;
      selected <= 1'b0;
    end else begin
      if (select) selected <= 1'b1;
      if (dec && degree != 7'd0) degree <= degree - 7'd1;
    end
  end

endmodule

// ----- rtl/mdvo_merge.sv -----
// Merging stage: registered minimum over all lanes, lowest index on ties.
// Depends on nothing outside this file.
module mdvo_merge #(
  parameter int N = 64
) (
  input  logic                 clk,
  input  logic [N-1:0]         cand,
  input  logic [N*7-1:0]       degrees,
  output logic                 found,
  output logic [$clog2(N)-1:0] best
);

  localparam int IW = $clog2(N);
  localparam int H = (N + 1) / 2;
  localparam int P = 1 << $clog2(H);

  logic [H-1:0]    h_val;
  logic [H*7-1:0]  h_deg;
  logic [H*IW-1:0] h_idx;

  // First level is registered; the rest is a short tree over half-width.
  always_ff @(posedge clk) begin
    for (int k = 0; k < H; k++) begin
      logic a, b;
      logic [6:0] da, db;
      a  = cand[2*k];
      da = degrees[2*k*7 +: 7];
      b  = (2*k+1 < N) ? cand[(2*k+1) % N] : 1'b0;
      db = degrees[((2*k+1) % N)*7 +: 7];
      h_val[k] <= a | b;
      if (a && (!b || da <= db)) begin
        h_deg[k*7 +: 7]   <= da;
        h_idx[k*IW +: IW] <= IW'(2*k);
      end else begin
        h_deg[k*7 +: 7]   <= db;
        h_idx[k*IW +: IW] <= IW'(2*k+1);
      end
    end
  end

  // Balanced pairwise tree; the lower half always sits on the left and wins ties.
  always_ff @(posedge clk) begin
    logic [P-1:0]  tv;
    logic [6:0]    td [P];
    logic [IW-1:0] ti [P];
    for (int k = 0; k < H; k++) begin
      tv[k] = h_val[k];
      td[k] = h_deg[k*7 +: 7];
      ti[k] = h_idx[k*IW +: IW];
    end
    for (int k = H; k < P; k++) begin
      tv[k] = 1'b0;
      td[k] = '1;
      ti[k] = '0;
    end
    for (int w = P >> 1; w >= 1; w = w >> 1) begin
      for (int k = 0; k < w; k++) begin
        if (tv[2*k] && (!tv[2*k+1] || td[2*k] <= td[2*k+1])) begin
          tv[k] = 1'b1; td[k] = td[2*k]; ti[k] = ti[2*k];
        end else begin
          tv[k] = tv[2*k+1]; td[k] = td[2*k+1]; ti[k] = ti[2*k+1];
        end
      end
    end
    found <= tv[0];
    best  <= ti[0];
  end

endmodule

// ----- rtl/min_degree_vertex_ordering.sv -----
// Minimum-degree vertex ordering. Rows load one per beat. The beat with
// last_row set starts the ordering: the DEGREE state computes all degrees
// in parallel lanes, then each selection waits for two registered merge
// levels, picks, and decrements the lanes; each emitted result waits in an
// output register until taken. The flush of zero-degree vertices emits each
// one via FLUSH and EMIT and steps over already selected ones in FLUSH. No
// input beat is accepted while an ordering runs. The user writes vertex_count
// through cfg_we/cfg_data while idle; the block does not enforce this.
module min_degree_vertex_ordering #(
  parameter int MAX_VERTICES = mdvo_pkg::MaxVertices
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mdvo_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mdvo_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data
);

  localparam int N = MAX_VERTICES;
  localparam int IW = $clog2(N);

  // Configured count, clamped into 1..N.
  logic [6:0] vertex_count;
  logic [6:0] n_eff;
  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 7'd64;
    else if (cfg_we) vertex_count <= cfg_data;
  end
  always_comb begin
    n_eff = vertex_count;
    if (n_eff == 7'd0) n_eff = 7'd1;
    if (n_eff > 7'(N)) n_eff = 7'(N);
  end

  // Adjacency rows as registers, one per lane; each lane reads its own.
  logic [N-1:0] adj [N];
  logic [N-1:0] mask;
  always_comb for (int j = 0; j < N; j++) mask[j] = (7'(j) < n_eff);

  mdvo_pkg::state_t state, state_next;
  logic [1:0]  wait_cnt, wait_cnt_next;
  logic [6:0]  pos, pos_next;
  logic [IW-1:0] pick, pick_next;
  logic [IW-1:0] scan, scan_next;
  logic        do_load, do_select, do_dec;
  logic        out_set;
  logic [IW-1:0] out_vertex;

  logic [N-1:0]   sel;
  logic [N*7-1:0] deg;
  logic [N-1:0]   cand;
  logic           found;
  logic [IW-1:0]  best;

  assign in_ready = (state == mdvo_pkg::ST_LOAD);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && 7'(in_data.row_index) < n_eff)
      adj[in_data.row_index[IW-1:0]] <= in_data.row_bits[N-1:0];
  end

  for (genvar i = 0; i < N; i++) begin : g_lane
    logic [N-1:0] above;
    logic [6:0]   init;
    always_comb begin
      above = '0;
      for (int j = 0; j < N; j++) above[j] = (j > i) && mask[j];
      init = 7'($countones(adj[i] & above));
    end
    mdvo_lane u_lane (
      .clk, .rst,
      .load(do_load),
      .init_degree(init),
      .select(do_select && pick == IW'(i)),
      .dec(do_dec && pick != IW'(i) && adj[i][pick] && mask[i]),
      .degree(deg[i*7 +: 7]),
      .selected(sel[i])
    );
    assign cand[i] = !sel[i] && mask[i] && deg[i*7 +: 7] != 7'd0;
  end

  mdvo_merge #(.N(N)) u_merge (
    .clk, .cand, .degrees(deg), .found, .best
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdvo_pkg::ST_LOAD;
      wait_cnt <= '0; pos <= '0; pick <= '0; scan <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next; wait_cnt <= wait_cnt_next; pos <= pos_next;
      pick <= pick_next; scan <= scan_next;
      if (out_set) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      out_data.position <= pos[5:0];
      out_data.vertex   <= 6'(out_vertex);
      out_data.last     <= (pos + 7'd1 == n_eff);
    end
  end

  // Sequencer: degree init, search, select/emit, decrement, then flush.
  always_comb begin
    state_next = state; wait_cnt_next = wait_cnt; pos_next = pos;
    pick_next = pick; scan_next = scan;
    do_load = 1'b0; do_select = 1'b0; do_dec = 1'b0;
    out_set = 1'b0; out_vertex = pick;
    unique case (state)
      mdvo_pkg::ST_LOAD: begin
        if (in_valid && in_data.last_row) begin
          state_next = mdvo_pkg::ST_DEGREE;
          pos_next = '0;
        end
      end
      mdvo_pkg::ST_DEGREE: begin
        do_load = 1'b1;
        wait_cnt_next = '0;
        state_next = mdvo_pkg::ST_SEARCH;
      end
      mdvo_pkg::ST_SEARCH: begin
        // Two merge register levels settle after lane state changed.
        if (wait_cnt != 2'd2) wait_cnt_next = wait_cnt + 2'd1;
        else if (!out_valid || out_ready) begin
          if (found) begin
            pick_next = best;
            out_vertex = best;
            out_set = 1'b1;
            state_next = mdvo_pkg::ST_UPDATE;
          end else begin
            scan_next = '0;
            state_next = mdvo_pkg::ST_FLUSH;
          end
        end
      end
      mdvo_pkg::ST_UPDATE: begin
        do_select = 1'b1; do_dec = 1'b1;
        pos_next = pos + 7'd1;
        wait_cnt_next = '0;
        state_next = (pos + 7'd1 == n_eff) ? mdvo_pkg::ST_LOAD
                                            : mdvo_pkg::ST_SEARCH;
      end
      mdvo_pkg::ST_FLUSH: begin
        if (!sel[scan] && mask[scan]) begin
          if (!out_valid || out_ready) begin
            out_vertex = scan; out_set = 1'b1;
            pick_next = scan;
            state_next = mdvo_pkg::ST_EMIT;
          end
        end else if (7'(scan) + 7'd1 >= n_eff) state_next = mdvo_pkg::ST_LOAD;
        else scan_next = scan + IW'(1);
      end
      mdvo_pkg::ST_EMIT: begin
        do_select = 1'b1;
        pos_next = pos + 7'd1;
        if (pos + 7'd1 == n_eff || 7'(scan) + 7'd1 >= n_eff)
          state_next = mdvo_pkg::ST_LOAD;
        else begin
          scan_next = scan + IW'(1);
          state_next = mdvo_pkg::ST_FLUSH;
        end
      end
      default: state_next = mdvo_pkg::ST_LOAD;
    endcase
  end

`ifndef SYNTHESIS
  // A new result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_set |-> (!out_valid || out_ready))
    else $error("result overwritten");
  // Input is blocked for the whole ordering.
  a_block_input: assert property (@(posedge clk) disable iff (rst)
    (state != mdvo_pkg::ST_LOAD) |-> !in_ready)
    else $error("input open during ordering");
  // Results never run past the vertex count.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    out_set |-> (pos < n_eff))
    else $error("too many results");
`endif

endmodule

// ----- dv/min_degree_vertex_ordering_test.sv -----
// Self-checking testbench for the minimum-degree vertex ordering block.
// Loads adjacency rows, predicts the ordering in the bench, and checks each result beat.
// Depends on rtl/mdvo_pkg.sv and rtl/min_degree_vertex_ordering.sv.
module min_degree_vertex_ordering_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 800000;
  localparam int LongHold = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mdvo_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mdvo_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  min_degree_vertex_ordering u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's state, kept up to date as beats are accepted.
  logic [63:0] row_mirror [64];
  logic [6:0] count_reg = 7'd64;
  mdvo_pkg::out_beat_t order_q [$];
  mdvo_pkg::in_beat_t row_q [$];

  int errors = 0;
  int rows_taken = 0;
  int orderings = 0;
  int results_seen = 0;
  int cycles = 0;

  // Long receiver hold requests: the stimulus bumps hold_req, the receiver serves them.
  int hold_req = 0;
  int hold_served = 0;

  function automatic int active_vertices();
    int n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > mdvo_pkg::MaxVertices) n = mdvo_pkg::MaxVertices;
    return n;
  endfunction

  // Builds the expected ordering from the mirrored rows and appends it to order_q.
  function automatic void predict_ordering();
    int n, pos, best, best_deg;
    int degree [64];
    bit picked [64];
    logic [63:0] mask, above;
    mdvo_pkg::out_beat_t beat;
    n = active_vertices();
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    pos = 0;
    for (int i = 0; i < 64; i++) begin
      degree[i] = 0;
      picked[i] = 1'b0;
    end
    // Degrees count only the upper triangle of each row.
    for (int i = 0; i < n; i++) begin
      above = (i + 1 >= 64) ? 64'd0 : (mask & ~((64'd1 << (i + 1)) - 64'd1));
      degree[i] = $countones(row_mirror[i] & above);
    end
    while (pos < n) begin
      best = 64;
      best_deg = 64;
      for (int i = 0; i < n; i++) begin
        if (!picked[i] && degree[i] > 0 && degree[i] < best_deg) begin
          best_deg = degree[i];
          best = i;
        end
      end
      if (best >= n) begin
        // No positive degree left: flush the rest in index order.
        for (int i = 0; i < n; i++) begin
          if (!picked[i]) begin
            picked[i] = 1'b1;
            beat.position = pos[5:0];
            beat.vertex = i[5:0];
            beat.last = (pos + 1 == n);
            order_q = {order_q, beat};
            pos++;
          end
        end
        break;
      end
      picked[best] = 1'b1;
      beat.position = pos[5:0];
      beat.vertex = best[5:0];
      beat.last = (pos + 1 == n);
      order_q = {order_q, beat};
      pos++;
      // Neighbors are found in column best; a zero degree stays at zero.
      for (int i = 0; i < n; i++) begin
        if (i != best && row_mirror[i][best] && degree[i] > 0) degree[i]--;
      end
    end
    orderings++;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, what, got, want);
  endtask

  // Input side of the mirror: rows within the active count are stored, and the
  // row that carries last_row starts a prediction.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      rows_taken++;
      if (in_data.row_index < active_vertices()) row_mirror[in_data.row_index] = in_data.row_bits;
      if (in_data.last_row) predict_ordering();
    end
  end

  // Result checker: every accepted beat is compared with the oldest expectation.
  always @(posedge clk) begin
    mdvo_pkg::out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (order_q.size() == 0) begin
        report("unexpected result beat, position", out_data.position, -1);
      end else begin
        want = order_q.pop_front();
        if (out_data.position !== want.position) report("position", out_data.position, want.position);
        if (out_data.vertex !== want.vertex) report("vertex", out_data.vertex, want.vertex);
        if (out_data.last !== want.last) report("last", out_data.last, want.last);
      end
    end
  end

  // Sender: bursts of beats with random gaps. A new beat is loaded only when
  // the previous one has been taken, so the payload holds steady while waiting.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (row_q.size() > 0) begin
        in_data <= row_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // About a third of the bursts run back to back with no gap.
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches among always ready, random stalls and heavy stalls
  // at random intervals, and serves requests for one long hold.
  int pattern = 0;
  int pattern_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served < hold_req) begin
      hold_served <= hold_served + 1;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern <= $urandom_range(2, 0);
        pattern_left <= $urandom_range(16, 80);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(1, 0));
        default: out_ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, order_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Waits until the sender has drained and every expected result has come, then
  // lets the block settle before anything else happens.
  task automatic wait_drained();
    do @(negedge clk);
    while (row_q.size() != 0 || in_valid || order_q.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_count(int value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = value[6:0];
  endtask

  // Queues one graph. The rows of the active vertices go out in shuffled order
  // (all of them, or a random subset when partial is set), mixed with rows
  // beyond the count that the block must drop. The final beat carries last_row.
  task automatic queue_graph(int n, int density, bit symmetric, bit partial);
    logic [63:0] adj [64];
    int order [64];
    int tmp, k, sent;
    bit b;
    mdvo_pkg::in_beat_t beat;
    for (int i = 0; i < 64; i++) begin
      adj[i] = '0;
      adj[i][i] = 1'($urandom_range(1, 0));
    end
    for (int i = 0; i < 64; i++) begin
      for (int j = i + 1; j < 64; j++) begin
        b = ($urandom_range(99, 0) < density);
        adj[i][j] = b;
        adj[j][i] = symmetric ? b : ($urandom_range(99, 0) < density);
      end
    end
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    sent = 0;
    for (int i = 0; i < n; i++) begin
      if (n < 64 && $urandom_range(4, 0) == 0) begin
        beat.row_index = 6'($urandom_range(63, n));
        beat.row_bits = {$urandom, $urandom};
        beat.last_row = 1'b0;
        row_q = {row_q, beat};
      end
      if (!partial || $urandom_range(1, 0) == 1) begin
        beat.row_index = 6'(order[i]);
        beat.row_bits = adj[order[i]];
        beat.last_row = 1'b0;
        row_q = {row_q, beat};
        sent++;
      end
    end
    // Sometimes the start comes on a row beyond the count, which is not stored.
    if (sent == 0 || (n < 64 && $urandom_range(9, 0) == 0)) begin
      beat.row_index = (n < 64) ? 6'($urandom_range(63, n)) : 6'(order[0]);
      beat.row_bits = (n < 64) ? {$urandom, $urandom} : adj[order[0]];
      beat.last_row = 1'b1;
      row_q = {row_q, beat};
    end else begin
      row_q[row_q.size() - 1].last_row = 1'b1;
    end
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The first graph fills every row at the reset count of 64, so no later
    // ordering can read a row that was never written.
    write_count(64);
    queue_graph(64, 50, 1'b1, 1'b0);

    // Directed corners: a single vertex, out-of-range counts, empty and
    // complete graphs, one-sided rows, and a start beat beyond the count.
    write_count(1);
    queue_graph(1, 100, 1'b1, 1'b0);
    write_count(0);
    queue_graph(1, 0, 1'b1, 1'b0);
    write_count(127);
    queue_graph(64, 100, 1'b1, 1'b1);
    write_count(65);
    queue_graph(64, 3, 1'b0, 1'b1);
    write_count(5);
    queue_graph(5, 0, 1'b1, 1'b0);
    queue_graph(5, 100, 1'b1, 1'b0);
    queue_graph(5, 50, 1'b0, 1'b0);
    begin
      mdvo_pkg::in_beat_t beat;
      beat.row_index = 6'd63;
      beat.row_bits = '1;
      beat.last_row = 1'b1;
      row_q = {row_q, beat};
    end

    // The stimulus pauses here until the sender has drained and every expected result has arrived.
    wait_drained();

    // Random part: mostly small graphs, a few at full size.
    while (rows_taken < 480) begin
      case ($urandom_range(9, 0))
        0: n = 64;
        1: n = $urandom_range(64, 20);
        2: n = $urandom_range(2, 1);
        default: n = $urandom_range(12, 2);
      endcase
      write_count(n);
      // Once in the run, the receiver holds off long enough for the block to
      // fill and stall its input while the sender keeps offering rows.
      if (hold_req == 0 && orderings > 12) hold_req = 1;
      repeat ($urandom_range(3, 1)) begin
        queue_graph(n, $urandom_range(100, 0), $urandom_range(3, 0) != 0,
                    $urandom_range(3, 0) == 0);
      end
    end

    wait_drained();
    $display("Covered %0d row beats, %0d orderings and %0d result beats,",
             rows_taken, orderings, results_seen);
    $display("with vertex counts from 1 to 64 and out-of-range count settings.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
